// ----- hw/rtl/gtp_pkg.sv -----
`timescale 1ns / 1ps
package gtp_pkg;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned XW = 52;
  localparam int unsigned ZW = 28;
  localparam logic signed [ZW-1:0] AngPi = 28'sd52707179;
  localparam logic signed [ZW:0] TwoPi = 29'sd105414358;
  localparam logic [23:0] InvK = 24'd10188014;

  localparam logic [2:0] RegDistGain = 3'd0;
  localparam logic [2:0] RegAngleGain = 3'd1;
  localparam logic [2:0] RegMaxLin = 3'd2;
  localparam logic [2:0] RegMaxTurn = 3'd3;
  localparam logic [2:0] RegArriveTol = 3'd4;
  localparam logic [2:0] RegRampTicks = 3'd5;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 28'sd13176795;
      5'd1: atan_lut = 28'sd7778716;
      5'd2: atan_lut = 28'sd4110060;
      5'd3: atan_lut = 28'sd2086331;
      5'd4: atan_lut = 28'sd1047214;
      5'd5: atan_lut = 28'sd524117;
      5'd6: atan_lut = 28'sd262123;
      5'd7: atan_lut = 28'sd131069;
      default: atan_lut = (i > 5'd24) ? 28'sd0 : (28'sd1 <<< (5'd24 - i));
    endcase
  endfunction
endpackage

// ----- hw/rtl/go_to_point_p_controller_top.sv -----
`timescale 1ns / 1ps
// Proportional go-to-goal controller.
// s_axis: one beat per control tick carrying pose and goal; m_axis: one beat
// per tick with the commanded speeds and the arrived flag. cfg: writes one of
// six registers by index (gains, caps, tolerance, ramp length).
// The accepted tick is registered, passes the row of CORDIC cells, then the
// scaling states StMul, StDist and StCalc; the result beat is then written
// into the output register. On a capped tick during the soft start the
// bit-serial divider runs between StCalc and the output register. A new tick
// is not taken before the previous one has left StCalc or the divider.
// One tick is in flight at a time; s_axis_tready rises again once the result
// beat has moved into the output register, so the next tick may enter while
// the result still waits for m_axis_tready.
// Reset clears the ramp counter, loads register defaults and empties the
// output register. A stalled receiver holds the result beat stable; ticks
// then wait in front of the block.
module go_to_point_p_controller_top #(
  parameter int unsigned CORDIC_STEPS = gtp_pkg::CordicSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], goal_x[111:80], goal_y[143:112]
  input  logic [143:0] s_axis_tdata,
  // new_goal
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lin_vel[14:0], ang_vel[30:15], arrived[31]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  typedef enum logic [5:0] {
    StIdle = 6'b000001, StCordic = 6'b000010, StMul = 6'b000100,
    StDist = 6'b001000, StCalc = 6'b010000, StDiv = 6'b100000
  } state_e;

  localparam int unsigned ZWE = 30;
  localparam logic [23:0] InvKx = gtp_pkg::InvK;

  state_e st_q, st_d;
  logic [15:0] dist_gain_q, angle_gain_q, ramp_ticks_q, ramp_count_q;
  logic [14:0] max_lin_q, max_turn_q;
  logic [30:0] tol_q;
  logic new_goal_q;
  logic signed [15:0] hd_q;
  logic [5:0] cnt_q;
  gtp_pkg::cordic_t chain [CORDIC_STEPS+1];
  logic [63:0] xq_prod_q;
  logic [32:0] dist_q;
  logic [48:0] v_q;
  logic signed [44:0] w_q;
  logic out_valid_q, out_valid_d;
  logic [31:0] out_data_q;
  logic div_start, div_done;
  logic [30:0] div_quo;
  logic [15:0] rc_eff, rc_new;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_gain_q <= 16'd256;
      angle_gain_q <= 16'd256;
      max_lin_q <= 15'd4096;
      max_turn_q <= 15'd8192;
      tol_q <= 31'd6554;
      ramp_ticks_q <= 16'd50;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gtp_pkg::RegDistGain: dist_gain_q <= cfg_data_i[15:0];
        gtp_pkg::RegAngleGain: angle_gain_q <= cfg_data_i[15:0];
        gtp_pkg::RegMaxLin: max_lin_q <= cfg_data_i[14:0];
        gtp_pkg::RegMaxTurn: max_turn_q <= cfg_data_i[14:0];
        gtp_pkg::RegArriveTol: tol_q <= cfg_data_i[30:0];
        gtp_pkg::RegRampTicks: ramp_ticks_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input stage: pre-rotate left half-plane vectors by pi
  logic signed [32:0] dx, dy;
  gtp_pkg::cordic_t c0_q;
  assign dx = $signed({s_axis_tdata[111], s_axis_tdata[111:80]})
            - $signed({s_axis_tdata[31], s_axis_tdata[31:0]});
  assign dy = $signed({s_axis_tdata[143], s_axis_tdata[143:112]})
            - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hd_q <= $signed(s_axis_tdata[79:64]);
      new_goal_q <= s_axis_tuser;
      if (dx < 0) begin
        c0_q.x <= -{{3{dx[32]}}, dx, 16'd0};
        c0_q.y <= -{{3{dy[32]}}, dy, 16'd0};
        c0_q.z <= (dy >= 0) ? gtp_pkg::AngPi : -gtp_pkg::AngPi;
      end else begin
        c0_q.x <= {{3{dx[32]}}, dx, 16'd0};
        c0_q.y <= {{3{dy[32]}}, dy, 16'd0};
        c0_q.z <= '0;
      end
    end
  end

  assign chain[0] = c0_q;
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    gtp_cell #(.Index(g)) u_cell (.clk_i(clk_i), .d_i(chain[g]), .q_o(chain[g+1]));
  end

  gtp_pkg::cordic_t res;
  assign res = chain[CORDIC_STEPS];

  // heading error wrap: |z - hd*2048| stays below one and a half turns, so two wrap steps suffice
  logic signed [ZWE-1:0] err0, err1, err2;
  assign err0 = ZWE'(res.z) - (ZWE'(hd_q) <<< 11);
  assign err1 = (err0 > ZWE'(gtp_pkg::AngPi)) ? err0 - ZWE'(gtp_pkg::TwoPi) :
                (err0 < -ZWE'(gtp_pkg::AngPi)) ? err0 + ZWE'(gtp_pkg::TwoPi) : err0;
  assign err2 = (err1 > ZWE'(gtp_pkg::AngPi)) ? err1 - ZWE'(gtp_pkg::TwoPi) :
                (err1 < -ZWE'(gtp_pkg::AngPi)) ? err1 + ZWE'(gtp_pkg::TwoPi) : err1;

  logic [36:0] xq;
  logic signed [28:0] err_q;
  assign xq = 37'((res.x + 52'sd32768) >>> 16);

  assign rc_eff = new_goal_q ? 16'd0 : ramp_count_q;
  assign rc_new = (rc_eff < ramp_ticks_q) ? rc_eff + 16'd1 : ramp_ticks_q;

  logic arrive;
  assign arrive = (dist_q <= {2'b0, tol_q});
  logic [15:0] w16;
  assign w16 = (w_q > $signed({30'd0, max_turn_q})) ? {1'b0, max_turn_q} :
               (w_q < -$signed({30'd0, max_turn_q})) ? -{1'b0, max_turn_q} : w_q[15:0];

  logic capped;
  assign capped = (v_q >= {34'd0, max_lin_q});
  assign div_start = (st_q == StCalc) && !arrive && capped && (rc_new < ramp_ticks_q);

  gtp_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i({1'b0, max_lin_q} * 31'(rc_new)), .den_i(ramp_ticks_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [15:0] ang_res_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (s_axis_tvalid) st_d = StCordic;
      StCordic: if (cnt_q == 6'(CORDIC_STEPS)) st_d = StMul;
      StMul: st_d = StDist;
      StDist: st_d = StCalc;
      StCalc: if (!out_valid_q || m_axis_tready) st_d = div_start ? StDiv : StIdle;
      StDiv: if (div_done) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if (st_q == StCalc && st_d != StCalc) out_valid_d = !div_start;
    if (st_q == StDiv && div_done) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      ramp_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= (st_q == StCordic) ? cnt_q + 6'd1 : 6'd0;
      out_valid_q <= out_valid_d;
      if (st_q == StCalc && st_d != StCalc) begin
        if (arrive) begin
          ramp_count_q <= rc_eff;
        end else begin
          ramp_count_q <= rc_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StCordic) begin
      xq_prod_q <= 64'(xq[35:0]) * 64'(InvKx);
      err_q <= 29'(err2);
    end
    if (st_q == StMul) begin
      dist_q <= 33'((xq_prod_q + 64'd8388608) >> 24);
      w_q <= $signed({1'b0, angle_gain_q}) * err_q >>> 19;
    end
    if (st_q == StDist) begin
      v_q <= 49'(({16'd0, dist_q} * 49'(dist_gain_q)) >> 12);
    end
    if (st_q == StCalc && st_d != StCalc) begin
      if (arrive) out_data_q <= 32'h8000_0000;
      else out_data_q <= {1'b0, w16, capped ? max_lin_q : v_q[14:0]};
      ang_res_q <= w16;
    end
    if (st_q == StDiv && div_done) out_data_q <= {1'b0, ang_res_q, div_quo[14:0]};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

`ifndef NO_ASSERTIONS
  a_ramp_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StCalc && st_d != StCalc && !arrive) |=>
      ramp_count_q <= $past(ramp_ticks_q))
    else $error("ramp count");
  a_arr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[31]) |-> m_axis_tdata[30:0] == 31'd0)
    else $error("arrived with motion");
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready)
    else $error("overlap");
`endif
endmodule

// ----- hw/rtl/gtp_cell.sv -----
`timescale 1ns / 1ps
module gtp_cell #(
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  gtp_pkg::cordic_t d_i,
  output gtp_pkg::cordic_t q_o
);
  localparam logic [4:0] Sh = 5'(Index);
  gtp_pkg::cordic_t nxt;

  always_comb begin
    nxt = d_i;
    if (d_i.y > 0) begin
      nxt.x = d_i.x + (d_i.y >>> Sh);
      nxt.y = d_i.y - (d_i.x >>> Sh);
      nxt.z = d_i.z + gtp_pkg::atan_lut(Sh);
    end else begin
      nxt.x = d_i.x - (d_i.y >>> Sh);
      nxt.y = d_i.y + (d_i.x >>> Sh);
      nxt.z = d_i.z - gtp_pkg::atan_lut(Sh);
    end
  end

  always_ff @(posedge clk_i) begin
    q_o <= nxt;
  end
endmodule

// ----- hw/rtl/gtp_div.sv -----
`timescale 1ns / 1ps
module gtp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [30:0] quo_o
);
  logic [30:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [16:0] trial;

  assign trial = {rem_q[15:0], quo_q[30]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[29:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[29:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd30) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd30);
  assign quo_o = {quo_d[30:0]};
endmodule

// ----- bench/go_to_point_p_controller_check.sv -----
`timescale 1ns / 1ps
module go_to_point_p_controller_check (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           mismatches_o,
  output int           pending_o
);
  localparam longint BearingPi = 64'sd52707179;
  localparam longint unsigned RecipGain = 64'd10188014;

  typedef struct packed {
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_x;
    logic signed [15:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } tick_t;

  typedef struct packed {
    logic               arrived;
    logic signed [15:0] ang_vel;
    logic [14:0]        lin_vel;
  } command_t;

  logic [15:0] dist_gain_q, angle_gain_q, ramp_ticks_q, ramp_count_q;
  logic [14:0] max_lin_q, max_turn_q;
  logic [30:0] arrive_tol_q;
  command_t    command_queue[$];

  function automatic longint bearing_step(input int i);
    case (i)
      0: return 13176795;
      1: return 7778716;
      2: return 4110060;
      3: return 2086331;
      4: return 1047214;
      5: return 524117;
      6: return 262123;
      7: return 131069;
      default: return (i > 24) ? 0 : (64'sd1 <<< (24 - i));
    endcase
  endfunction

  function automatic command_t steer_toward(input tick_t t, input logic new_goal,
                                            inout logic [15:0] ramp);
    longint x, y, z, xs, ys, err, w, hd;
    longint unsigned xq, span, v;
    command_t c;
    x = (longint'(t.goal_x) - longint'(t.pos_x)) * 65536;
    y = (longint'(t.goal_y) - longint'(t.pos_y)) * 65536;
    hd = longint'(t.heading);
    z = 0;
    c = '0;
    if (new_goal) ramp = 0;
    if (x < 0) begin
      z = (y >= 0) ? BearingPi : -BearingPi;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < gtp_pkg::CordicSteps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + bearing_step(i);
      end else begin
        x = x - ys; y = y + xs; z = z - bearing_step(i);
      end
    end
    xq = (longint'(x) + 32768) >>> 16;
    span = (xq * RecipGain + (64'd1 << 23)) >> 24;
    if (span <= arrive_tol_q) begin
      c.arrived = 1'b1;
      return c;
    end
    if (ramp < ramp_ticks_q) ramp = ramp + 16'd1;
    else ramp = ramp_ticks_q;
    v = (longint'(dist_gain_q) * span) >> 12;
    if (v >= max_lin_q) begin
      v = max_lin_q;
      if (ramp < ramp_ticks_q) v = (longint'(max_lin_q) * ramp) / ramp_ticks_q;
    end
    err = z - hd * 2048;
    while (err > BearingPi || err < -BearingPi) begin
      if (err > 0) err = err - 2 * BearingPi;
      else err = err + 2 * BearingPi;
    end
    w = (longint'(angle_gain_q) * err) >>> 19;
    if (w > longint'(max_turn_q)) w = max_turn_q;
    if (w < -longint'(max_turn_q)) w = -longint'(max_turn_q);
    c.lin_vel = v[14:0];
    c.ang_vel = w[15:0];
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    command_t want, got;
    logic [15:0] ramp;
    if (!rst_ni) begin
      dist_gain_q <= 16'd256;
      angle_gain_q <= 16'd256;
      max_lin_q <= 15'd4096;
      max_turn_q <= 15'd8192;
      arrive_tol_q <= 31'd6554;
      ramp_ticks_q <= 16'd50;
      ramp_count_q <= '0;
      mismatches_o <= 0;
      pending_o <= 0;
      command_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gtp_pkg::RegDistGain:  dist_gain_q <= cfg_data_i[15:0];
          gtp_pkg::RegAngleGain: angle_gain_q <= cfg_data_i[15:0];
          gtp_pkg::RegMaxLin:    max_lin_q <= cfg_data_i[14:0];
          gtp_pkg::RegMaxTurn:   max_turn_q <= cfg_data_i[14:0];
          gtp_pkg::RegArriveTol: arrive_tol_q <= cfg_data_i[30:0];
          gtp_pkg::RegRampTicks: ramp_ticks_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ramp = ramp_count_q;
        command_queue.insert(command_queue.size(),
                             steer_toward(tick_t'(s_axis_tdata), s_axis_tuser, ramp));
        ramp_count_q <= ramp;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = command_t'(m_axis_tdata);
        if (command_queue.size() == 0) begin
          if (mismatches_o < 10) $display("unexpected command beat %h", got);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = command_queue.pop_front();
          if (got !== want) begin
            if (mismatches_o < 10)
              $display("command mismatch: lin %0d/%0d ang %0d/%0d arrived %0b/%0b",
                       want.lin_vel, got.lin_vel, want.ang_vel, got.ang_vel,
                       want.arrived, got.arrived);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      pending_o <= command_queue.size();
    end
  end
endmodule

// ----- bench/go_to_point_p_controller_top_test.sv -----
`timescale 1ns / 1ps
module go_to_point_p_controller_top_test;
  localparam int StallLimit = 5000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  int           mismatches, pending, rx_stall;
  int           idle_cycles = 0;
  logic         quiet = 1'b0;

  go_to_point_p_controller_top DUT (.*);

  go_to_point_p_controller_check checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .mismatches_o(mismatches), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= (rx_stall == 1);
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      rx_stall <= $urandom_range(1, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_tick(input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] hd, input logic [31:0] gx,
                           input logic [31:0] gy, input logic ng);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tdata <= {gy, gx, hd, py, px};
    s_axis_tuser <= ng;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] v[6]);
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_index_i <= 3'(i);
      cfg_data_i <= v[i];
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 20000) - 10000;
      default: return $signed($urandom) >>> $urandom_range(8, 30);
    endcase
  endfunction

  task automatic run_goals(input int count);
    logic [31:0] gx, gy, ox, oy;
    logic [15:0] hd;
    int n, sent;
    sent = 0;
    while (sent < count) begin
      gx = $urandom;
      gy = $urandom;
      ox = pick_offset();
      oy = pick_offset();
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
        hd = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 51472) - 25736);
        send_tick(gx - ox, gy - oy, hd, gx, gy,
                  (k == 0) || ($urandom_range(0, 15) == 0));
        if ($urandom_range(0, 1)) begin
          ox = $signed(ox) >>> 1;
          oy = $signed(oy) >>> 1;
        end
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_tick($urandom, $urandom, 16'($urandom), $urandom, $urandom, 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] s[6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    s = '{32'd256, 32'd256, 32'd4096, 32'd8192, 32'd6554, 32'd50};
    load_settings(s);
    send_tick(32'd5, 32'd7, 16'd0, 32'd5, 32'd7, 1'b1);
    send_tick(32'd0, 32'd0, 16'd0, 32'd3000, 32'd0, 1'b0);
    send_tick(32'h8000_0000, 32'h8000_0000, 16'sd25736, 32'h7fff_ffff, 32'h7fff_ffff,
              1'b1);
    send_tick(32'h7fff_ffff, 32'h7fff_ffff, -16'sd25736, 32'h8000_0000,
              32'h8000_0000, 1'b0);
    send_tick(32'd0, 32'd0, 16'h8000, -32'sd100000, 32'd100000, 1'b0);
    send_tick(32'd0, 32'd0, 16'h7fff, -32'sd100000, -32'sd100000, 1'b0);
    send_tick(32'd0, 32'd0, 16'hffff, -32'sd100000, 32'd0, 1'b0);
    send_tick(32'd0, 32'd0, 16'd0, 32'd0, -32'sd9000000, 1'b0);
    for (int k = 0; k < 6; k++)
      send_tick(32'd0, 32'd0, 16'd1000, 32'd60000000, 32'd1, k == 0);

    s = '{32'hffff, 32'hffff, 32'h7fff, 32'h7fff, 32'h7fff_ffff, 32'hffff};
    load_settings(s);
    send_tick(32'h8000_0000, 32'd0, 16'd0, 32'h7fff_ffff, 32'd0, 1'b1);
    send_tick(32'd0, 32'd0, 16'd0, 32'd1000, 32'd1000, 1'b0);
    run_goals(60);

    s = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1};
    load_settings(s);
    send_tick(32'd0, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1);
    send_tick(32'd0, 32'd0, 16'd0, 32'd1, 32'd0, 1'b0);
    run_goals(100);

    s = '{32'hffff, 32'hffff, 32'h7fff, 32'h7fff, 32'd0, 32'd0};
    load_settings(s);
    run_goals(80);

    s = '{32'hffff, 32'h4000, 32'h7fff, 32'h7fff, 32'd100, 32'hffff};
    load_settings(s);
    run_goals(130);

    for (int p = 0; p < 3; p++) begin
      s = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
            $urandom_range(0, 32767), $urandom_range(0, 32767),
            $urandom >> $urandom_range(1, 31), $urandom_range(1, 300)};
      load_settings(s);
      if (p == 2) quiet = 1'b1;
      run_goals(160);
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
